// ===== hw/rtl/bsws_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_pkg: shared types and constants for the bounded stack with sort
// Stack geometry, operation codes, datapath command codes and the status
// bundle that the datapath returns to the controller.
// ----------------------------------------------------------------------------
package bsws_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FUNC_W = 2;

  localparam logic [FUNC_W-1:0] FN_PUSH = FUNC_W'(0);
  localparam logic [FUNC_W-1:0] FN_POP  = FUNC_W'(1);
  localparam logic [FUNC_W-1:0] FN_SORT = FUNC_W'(2);

  typedef enum logic [2:0] {
    CMD_IDLE,
    CMD_NOP,
    CMD_PUSH,
    CMD_POP,
    CMD_SORT_INIT,
    CMD_LOAD_KEY,
    CMD_SHIFT,
    CMD_PLACE
  } cmd_e;

  typedef struct packed {
    logic count_lt2;
    logic key_gt;
    logic pos_is_one;
    logic i_last;
  } dp_status_t;

endpackage

// ===== hw/rtl/bsws_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_dp: stack datapath
// Entry memory with one write and one registered read port, fill count,
// last popped value and the key, index and position registers of the sort.
// ----------------------------------------------------------------------------
module bsws_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bsws_pkg::cmd_e                      cmd_i,
  input  logic signed [bsws_pkg::DATA_W-1:0]  push_value_i,
  output bsws_pkg::dp_status_t                dp_status_o,
  output logic                                status_o,
  output logic signed [bsws_pkg::DATA_W-1:0]  popped_value_o,
  output logic [bsws_pkg::CNT_W-1:0]          fill_count_o
);

  logic [bsws_pkg::DATA_W-1:0] mem [bsws_pkg::DEPTH];
  logic [bsws_pkg::DATA_W-1:0] rd_data_q;

  logic                         we;
  logic [bsws_pkg::ADDR_W-1:0]  waddr;
  logic [bsws_pkg::DATA_W-1:0]  wdata;
  logic                         rd_en;
  logic [bsws_pkg::ADDR_W-1:0]  rd_addr;

  logic [bsws_pkg::CNT_W-1:0]   count_q, count_d, count_m1;
  logic                         status_q, status_d;
  logic                         pend_q, pend_d;
  logic [bsws_pkg::DATA_W-1:0]  last_popped_q;
  logic [bsws_pkg::DATA_W-1:0]  key_q, key_d;
  logic [bsws_pkg::ADDR_W-1:0]  i_q, i_d, pos_q, pos_d;
  logic                         full, empty;

  assign full     = (count_q == bsws_pkg::CNT_W'(bsws_pkg::DEPTH));
  assign empty    = (count_q == '0);
  assign count_m1 = count_q - bsws_pkg::CNT_W'(1);

  always_comb begin
    we       = 1'b0;
    waddr    = pos_q;
    wdata    = key_q;
    rd_en    = 1'b0;
    rd_addr  = i_q;
    count_d  = count_q;
    status_d = status_q;
    pend_d   = 1'b0;
    key_d    = key_q;
    i_d      = i_q;
    pos_d    = pos_q;
    unique case (cmd_i)
      bsws_pkg::CMD_PUSH: begin
        status_d = full;
        if (!full) begin
          we      = 1'b1;
          waddr   = count_q[bsws_pkg::ADDR_W-1:0];
          wdata   = push_value_i;
          count_d = count_q + bsws_pkg::CNT_W'(1);
        end
      end
      bsws_pkg::CMD_POP: begin
        status_d = empty;
        if (!empty) begin
          rd_en   = 1'b1;
          rd_addr = count_m1[bsws_pkg::ADDR_W-1:0];
          count_d = count_m1;
          pend_d  = 1'b1;
        end
      end
      bsws_pkg::CMD_NOP: begin
        status_d = 1'b0;
      end
      bsws_pkg::CMD_SORT_INIT: begin
        status_d = 1'b0;
        i_d      = bsws_pkg::ADDR_W'(1);
        rd_en    = 1'b1;
        rd_addr  = bsws_pkg::ADDR_W'(1);
      end
      bsws_pkg::CMD_LOAD_KEY: begin
        key_d   = rd_data_q;
        pos_d   = i_q;
        rd_en   = 1'b1;
        rd_addr = i_q - bsws_pkg::ADDR_W'(1);
      end
      bsws_pkg::CMD_SHIFT: begin
        // move the smaller neighbour up one place and look one further down
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = rd_data_q;
        pos_d   = pos_q - bsws_pkg::ADDR_W'(1);
        rd_en   = 1'b1;
        rd_addr = pos_q - bsws_pkg::ADDR_W'(2);
      end
      bsws_pkg::CMD_PLACE: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = key_q;
        i_d     = i_q + bsws_pkg::ADDR_W'(1);
        rd_en   = 1'b1;
        rd_addr = i_q + bsws_pkg::ADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
    key_q <= key_d;
    i_q   <= i_d;
    pos_q <= pos_d;
  end

  // a pop leaves its word in the read register while pend_q is set, then commits it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q       <= '0;
      status_q      <= 1'b0;
      pend_q        <= 1'b0;
      last_popped_q <= '0;
    end else begin
      count_q  <= count_d;
      status_q <= status_d;
      pend_q   <= pend_d;
      if (pend_q) begin
        last_popped_q <= rd_data_q;
      end
    end
  end

  assign popped_value_o = pend_q ? rd_data_q : last_popped_q;
  assign status_o       = status_q;
  assign fill_count_o   = count_q;

  assign dp_status_o.count_lt2  = (count_q < bsws_pkg::CNT_W'(2));
  assign dp_status_o.key_gt     = ($signed(key_q) > $signed(rd_data_q));
  assign dp_status_o.pos_is_one = (pos_q == bsws_pkg::ADDR_W'(1));
  assign dp_status_o.i_last     = (i_q == count_m1[bsws_pkg::ADDR_W-1:0]);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= bsws_pkg::CNT_W'(bsws_pkg::DEPTH))
    else $error("fill count beyond depth");
`endif

endmodule

// ===== hw/rtl/bsws_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsws_ctrl: stack controller
// Decodes accepted words into datapath commands and sequences the
// insertion sort over the entry memory.
// ----------------------------------------------------------------------------
module bsws_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [bsws_pkg::FUNC_W-1:0]   func_i,
  input  bsws_pkg::dp_status_t          dp_status_i,
  output bsws_pkg::cmd_e                cmd_o,
  output logic                          busy_o,
  output logic                          done_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_KEY  = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_PUT  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = bsws_pkg::CMD_IDLE;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          unique case (func_i)
            bsws_pkg::FN_PUSH: begin
              cmd_o  = bsws_pkg::CMD_PUSH;
              done_d = 1'b1;
            end
            bsws_pkg::FN_POP: begin
              cmd_o  = bsws_pkg::CMD_POP;
              done_d = 1'b1;
            end
            bsws_pkg::FN_SORT: begin
              if (dp_status_i.count_lt2) begin
                cmd_o  = bsws_pkg::CMD_NOP;
                done_d = 1'b1;
              end else begin
                cmd_o   = bsws_pkg::CMD_SORT_INIT;
                state_d = ST_KEY;
              end
            end
            default: begin
              cmd_o  = bsws_pkg::CMD_NOP;
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_KEY: begin
        cmd_o   = bsws_pkg::CMD_LOAD_KEY;
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (dp_status_i.key_gt) begin
          cmd_o = bsws_pkg::CMD_SHIFT;
          if (dp_status_i.pos_is_one) begin
            state_d = ST_PUT;
          end
        end else begin
          cmd_o = bsws_pkg::CMD_PLACE;
          if (dp_status_i.i_last) begin
            state_d = ST_IDLE;
            done_d  = 1'b1;
          end else begin
            state_d = ST_KEY;
          end
        end
      end
      ST_PUT: begin
        // key has passed every entry below it: it goes to the bottom
        cmd_o = bsws_pkg::CMD_PLACE;
        if (dp_status_i.i_last) begin
          state_d = ST_IDLE;
          done_d  = 1'b1;
        end else begin
          state_d = ST_KEY;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (state_q == ST_IDLE))
    else $error("result strobe while sort still running");
  a_push_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i == bsws_pkg::FN_PUSH)) |=> done_q)
    else $error("push word without result in next cycle");
  a_key_then_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KEY) |=> (state_q == ST_CMP))
    else $error("key load not followed by compare");
`endif

endmodule

// ===== hw/rtl/bounded_stack_with_sort.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_stack_with_sort: bounded stack of signed words with in-place sort
// Push, pop and a descending insertion sort over a 16-entry stack.
// ----------------------------------------------------------------------------
// Usage:
//   A command word (func_i, push_value_i) is taken at a rising edge with
//   start high and busy low. Exactly one result word per command comes back
//   on status_o, popped_value_o and fill_count_o, valid while done_o is high
//   for a single cycle; the receiver cannot hold it off.
//   Push, pop, the unused code and a sort of fewer than two entries give
//   their result in the cycle after acceptance and busy stays low, so one
//   command per cycle is sustained.
//   A sort of two or more entries raises busy and runs the insertion sort
//   through the single-write, registered-read entry memory: per key a load
//   step, then a compare step that shifts a neighbour up or places the key,
//   repeated until placed, with a separate placement step when the key sinks
//   to the bottom; done_o rises in the cycle after the last placement and
//   busy drops with it.
//   Reset empties the stack and clears the last popped value to zero; the
//   entry memory itself is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module bounded_stack_with_sort (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [bsws_pkg::FUNC_W-1:0]         func_i,
  input  logic signed [bsws_pkg::DATA_W-1:0]  push_value_i,
  output logic                                done_o,
  output logic                                status_o,
  output logic signed [bsws_pkg::DATA_W-1:0]  popped_value_o,
  output logic [bsws_pkg::CNT_W-1:0]          fill_count_o
);

  bsws_pkg::cmd_e       cmd;
  bsws_pkg::dp_status_t dp_status;

  bsws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .func_i      (func_i),
    .dp_status_i (dp_status),
    .cmd_o       (cmd),
    .busy_o      (busy),
    .done_o      (done_o)
  );

  bsws_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .push_value_i   (push_value_i),
    .dp_status_o    (dp_status),
    .status_o       (status_o),
    .popped_value_o (popped_value_o),
    .fill_count_o   (fill_count_o)
  );

endmodule
